// ===== sv/fve_pkg.sv =====
// ============================================================================
// fve_pkg - shared types and constants for the form variable extractor
// Character, status and phase codes, register indexes, result word type, helpers.
// ============================================================================
package fve_pkg;

    // Character codes
    localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
    localparam logic [7:0] CH_EQ      = 8'h3D;  // '='
    localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
    localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '

    // Status codes
    localparam logic [2:0] ST_FOUND   = 3'd0;
    localparam logic [2:0] ST_MISSING = 3'd1;
    localparam logic [2:0] ST_FAILED  = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_NOCAP   = 3'd4;

    // Search phase codes
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_NAME_LOW  = 3'd0;
    localparam logic [2:0] REG_NAME_HIGH = 3'd1;
    localparam logic [2:0] REG_NAME_LEN  = 3'd2;
    localparam logic [2:0] REG_CAPACITY  = 3'd3;
    localparam logic [2:0] REG_PLUS      = 3'd4;

    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    // One result word
    typedef struct packed {
        logic        is_status;
        logic [7:0]  value_byte;
        logic [2:0]  status_code;
        logic [15:0] value_length;
        logic        run_end;
    } result_t;

    // ASCII upper case to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Hex digit value; bit 4 set when c is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b0, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r = {1'b0, 4'(c - 8'h57)};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== sv/form_variable_extractor.sv =====
// Result words are registered in a 4-deep result queue and offered from it.
// Throughput: one input word per cycle while s_tready is high, which drops
// while fewer than two queue slots are free; the final word of a string that
// also decodes a byte yields two result words, drained one per cycle on m_tready.
// Reset: rst_n asynchronous, active low; resets run state, queue pointers, config.
// ============================================================================
// form_variable_extractor - query/form variable lookup and percent decoder
// Scans a byte stream for the first name=value segment whose name matches the
// configured name (case-insensitive), percent-decodes its value and emits the
// decoded bytes followed by one status word per string.
// ============================================================================
module form_variable_extractor #(
    parameter int NAME_MAX_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] char_in
    input  logic        s_tuser,     // [0] empty_string
    input  logic        s_tlast,     // final_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [7:0] value_byte, [10:8] status_code,
                                     // [26:11] value_length, [31:27] zero
    output logic        m_tuser,     // [0] is_status
    output logic        m_tlast      // run_end
);
    import fve_pkg::*;

    localparam int POSW = $clog2(NAME_MAX_BYTES + 1);
    localparam int IDXW = (NAME_MAX_BYTES > 1) ? $clog2(NAME_MAX_BYTES) : 1;
    localparam int QDEPTH = 4;
    localparam int QPW = 2;
    localparam int QCW = 3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NAME_MAX_BYTES-1:0][7:0] name_bytes_reg;
    logic [4:0]  name_length_reg;
    logic [15:0] capacity_reg;
    logic        plus_is_space_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_bytes_reg    <= '0;
            name_length_reg   <= '0;
            capacity_reg      <= CAPACITY_RESET;
            plus_is_space_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < NAME_MAX_BYTES; i++)
            begin
                if (i < 8 && cfg_index == REG_NAME_LOW)
                begin
                    name_bytes_reg[i] <= cfg_data[(i % 8) * 8 +: 8];
                end
                if (i >= 8 && cfg_index == REG_NAME_HIGH)
                begin
                    name_bytes_reg[i] <= cfg_data[(i % 8) * 8 +: 8];
                end
            end
            if (cfg_index == REG_NAME_LEN)
            begin
                name_length_reg <= cfg_data[4:0];
            end
            if (cfg_index == REG_CAPACITY)
            begin
                capacity_reg <= cfg_data[15:0];
            end
            if (cfg_index == REG_PLUS)
            begin
                plus_is_space_reg <= cfg_data[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Run state
    // ------------------------------------------------------------------
    logic [POSW-1:0] seg_pos_reg,  seg_pos_next;
    logic            mismatch_reg, mismatch_next;
    logic [1:0]      phase_reg,    phase_next;
    logic [1:0]      esc_cnt_reg,  esc_cnt_next;
    logic [3:0]      esc_nib_reg,  esc_nib_next;
    logic [15:0]     dec_cnt_reg,  dec_cnt_next;
    logic            failed_reg,   failed_next;

    // result queue
    result_t        queue_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] q_cnt_reg,  q_cnt_next;

    logic           in_fire, out_fire;
    logic [1:0]     push_num;
    result_t        res_a, res_b;

    logic [POSW-1:0] name_len_eff;
    logic [7:0]      c;
    logic [4:0]      hex;
    logic [16:0]     cnt_plus1;

    assign in_fire  = s_tvalid & s_tready;
    assign out_fire = m_tvalid & m_tready;
    assign c        = s_tdata;
    assign hex      = hex_value(c);
    assign cnt_plus1 = {1'b0, dec_cnt_reg} + 17'd1;
    assign name_len_eff = (name_length_reg > 5'(NAME_MAX_BYTES))
                        ? POSW'(NAME_MAX_BYTES) : POSW'(name_length_reg);

    // ------------------------------------------------------------------
    // Per-word decode: search, value decode and status
    // ------------------------------------------------------------------
    always_comb
    begin
        logic    emit;
        result_t byte_res;
        result_t stat_res;

        seg_pos_next  = seg_pos_reg;
        mismatch_next = mismatch_reg;
        phase_next    = phase_reg;
        esc_cnt_next  = esc_cnt_reg;
        esc_nib_next  = esc_nib_reg;
        dec_cnt_next  = dec_cnt_reg;
        failed_next   = failed_reg;
        emit          = 1'b0;
        byte_res      = '0;
        stat_res      = '0;
        stat_res.is_status = 1'b1;
        stat_res.run_end   = 1'b1;
        res_a    = '0;
        res_b    = '0;
        push_num = 2'd0;

        if (in_fire)
        begin
            if (s_tuser)
            begin
                // empty string: status only, run cleared
                stat_res.status_code = (capacity_reg == 16'd0) ? ST_NOCAP : ST_EMPTY;
                res_a    = stat_res;
                push_num = 2'd1;
            end
            else
            begin
                case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (c == CH_AMP)
                        begin
                            seg_pos_next  = '0;
                            mismatch_next = 1'b0;
                        end
                        else if (seg_pos_reg < name_len_eff)
                        begin
                            if (fold_case(c) != fold_case(name_bytes_reg[seg_pos_reg[IDXW-1:0]]))
                            begin
                                mismatch_next = 1'b1;
                            end
                            seg_pos_next = seg_pos_reg + POSW'(1);
                        end
                        else if (!mismatch_reg && c == CH_EQ)
                        begin
                            phase_next = PH_VALUE;
                        end
                        else
                        begin
                            mismatch_next = 1'b1;
                        end
                    end
                    PH_VALUE:
                    begin
                        if (c == CH_AMP)
                        begin
                            if (esc_cnt_reg != 2'd0)
                            begin
                                failed_next  = 1'b1;
                                esc_cnt_next = 2'd0;
                            end
                            phase_next = PH_DONE;
                        end
                        else if (esc_cnt_reg == 2'd0)
                        begin
                            if (cnt_plus1 >= {1'b0, capacity_reg})
                            begin
                                failed_next = 1'b1;
                                phase_next  = PH_DONE;
                            end
                            else if (c == CH_PERCENT)
                            begin
                                esc_cnt_next = 2'd1;
                            end
                            else
                            begin
                                emit = 1'b1;
                                byte_res.value_byte =
                                    (plus_is_space_reg && c == CH_PLUS) ? CH_SPACE : c;
                                dec_cnt_next = cnt_plus1[15:0];
                            end
                        end
                        else if (hex[4])
                        begin
                            failed_next  = 1'b1;
                            phase_next   = PH_DONE;
                            esc_cnt_next = 2'd0;
                        end
                        else if (esc_cnt_reg == 2'd1)
                        begin
                            esc_nib_next = hex[3:0];
                            esc_cnt_next = 2'd2;
                        end
                        else
                        begin
                            emit = 1'b1;
                            byte_res.value_byte = {esc_nib_reg, hex[3:0]};
                            dec_cnt_next = cnt_plus1[15:0];
                            esc_cnt_next = 2'd0;
                        end
                    end
                    default:
                    begin
                        // value closed: ignore bytes until the final word
                    end
                endcase

                // final word: status from the updated state
                if (capacity_reg == 16'd0)
                begin
                    stat_res.status_code = ST_NOCAP;
                end
                else if (phase_next == PH_SEARCH)
                begin
                    stat_res.status_code = ST_MISSING;
                end
                else if (failed_next || esc_cnt_next != 2'd0)
                begin
                    stat_res.status_code = ST_FAILED;
                end
                else
                begin
                    stat_res.status_code  = ST_FOUND;
                    stat_res.value_length = dec_cnt_next;
                end

                if (emit)
                begin
                    res_a = byte_res;
                    res_b = stat_res;
                    push_num = s_tlast ? 2'd2 : 2'd1;
                end
                else if (s_tlast)
                begin
                    res_a    = stat_res;
                    push_num = 2'd1;
                end
            end

            // any status word returns the run to its start
            if (s_tuser || s_tlast)
            begin
                seg_pos_next  = '0;
                mismatch_next = 1'b0;
                phase_next    = PH_SEARCH;
                esc_cnt_next  = 2'd0;
                esc_nib_next  = 4'd0;
                dec_cnt_next  = 16'd0;
                failed_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_pos_reg  <= '0;
            mismatch_reg <= 1'b0;
            phase_reg    <= PH_SEARCH;
            esc_cnt_reg  <= 2'd0;
            esc_nib_reg  <= 4'd0;
            dec_cnt_reg  <= 16'd0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            seg_pos_reg  <= seg_pos_next;
            mismatch_reg <= mismatch_next;
            phase_reg    <= phase_next;
            esc_cnt_reg  <= esc_cnt_next;
            esc_nib_reg  <= esc_nib_next;
            dec_cnt_reg  <= dec_cnt_next;
            failed_reg   <= failed_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two pushes, one pop per cycle
    // ------------------------------------------------------------------
    assign q_cnt_next = q_cnt_reg + QCW'(push_num) - QCW'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPW'(push_num);
            rd_ptr_reg <= rd_ptr_reg + QPW'(out_fire);
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res_a;
        end
        if (push_num == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPW'(1)] <= res_b;
        end
    end

    // ------------------------------------------------------------------
    // Stream outputs
    // ------------------------------------------------------------------
    assign s_tready = (q_cnt_reg <= QCW'(QDEPTH - 2));
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = {5'd0, queue_reg[rd_ptr_reg].value_length,
                       queue_reg[rd_ptr_reg].status_code,
                       queue_reg[rd_ptr_reg].value_byte};
    assign m_tuser  = queue_reg[rd_ptr_reg].is_status;
    assign m_tlast  = queue_reg[rd_ptr_reg].run_end;

`ifndef SYNTHESIS
    // queue never holds more words than it has slots
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= QCW'(QDEPTH))
        else $error("result queue overflow");

    // a status word always closes its run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("status word without run end");

    // the end of a string returns the scan to its start
    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tlast || s_tuser)) |=>
            (phase_reg == PH_SEARCH && dec_cnt_reg == 16'd0 && esc_cnt_reg == 2'd0))
        else $error("run state not cleared at string end");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb - regression for the form variable extractor
// Feeds directed and random query strings through the input stream, predicts
// the decoded value words and the closing status word of every string, and
// checks each result word in order. Sides idle at random as each phase selects.
// ============================================================================
module tb;
    import fve_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 22;
    localparam int DRAIN_CYCLES = 8;
    localparam int NAME_BYTES   = 16;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register copies, per-string scan state, expected words
    // ------------------------------------------------------------------------
    class lookup_scoreboard;
        logic [63:0] name_lo;
        logic [63:0] name_hi;
        logic [4:0]  name_size;
        logic [15:0] cap;
        logic        plus_space;

        logic [4:0]  seg_pos;
        logic        seg_miss;
        logic [1:0]  scan_phase;
        logic [1:0]  esc_cnt;
        logic [3:0]  esc_hi;
        logic [15:0] dec_cnt;
        logic        dec_fail;

        result_t     expected_words[$];
        int          errors;

        function new();
            name_lo    = '0;
            name_hi    = '0;
            name_size  = '0;
            cap        = CAPACITY_RESET;
            plus_space = 1'b1;
            errors     = 0;
            clear_run();
        endfunction

        function void clear_run();
            seg_pos    = '0;
            seg_miss   = 1'b0;
            scan_phase = PH_SEARCH;
            esc_cnt    = '0;
            esc_hi     = '0;
            dec_cnt    = '0;
            dec_fail   = 1'b0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_NAME_LOW:  name_lo = val;
                REG_NAME_HIGH: name_hi = val;
                REG_NAME_LEN:  name_size = val[4:0];
                REG_CAPACITY:  cap = val[15:0];
                REG_PLUS:      plus_space = val[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] name_char(int i);
            if (i < 8)
                return name_lo[i*8 +: 8];
            return name_hi[(i-8)*8 +: 8];
        endfunction

        function logic [7:0] to_lower(logic [7:0] c);
            if (c >= 8'h41 && c <= 8'h5A)
                return c | 8'h20;
            return c;
        endfunction

        // low nibble in [3:0], bit 4 set for a non-hex byte
        function logic [4:0] hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return {1'b0, c[3:0]};
            if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
                return {1'b0, c[3:0] + 4'd9};
            return 5'h10;
        endfunction

        function void push_word(logic is_st, logic [7:0] b, logic [2:0] code,
                                logic [15:0] len, logic closes);
            result_t w;
            w.is_status    = is_st;
            w.value_byte   = b;
            w.status_code  = code;
            w.value_length = len;
            w.run_end      = closes;
            expected_words.push_back(w);
        endfunction

        // name matching while no value has been opened
        function void scan_search(logic [7:0] c);
            logic [4:0] nlen;
            nlen = (name_size > 5'(NAME_BYTES)) ? 5'(NAME_BYTES) : name_size;
            if (c == CH_AMP)
            begin
                seg_pos  = '0;
                seg_miss = 1'b0;
            end
            else if (seg_pos < nlen)
            begin
                if (to_lower(c) != to_lower(name_char(seg_pos)))
                    seg_miss = 1'b1;
                seg_pos++;
            end
            else if (!seg_miss && c == CH_EQ)
                scan_phase = PH_VALUE;
            else
                seg_miss = 1'b1;
        endfunction

        // percent decoding of the matched value
        function void scan_value(logic [7:0] c);
            logic [4:0] h;
            if (c == CH_AMP)
            begin
                if (esc_cnt != 0)
                begin
                    dec_fail = 1'b1;
                    esc_cnt  = '0;
                end
                scan_phase = PH_DONE;
            end
            else if (esc_cnt == 0)
            begin
                if (int'(dec_cnt) + 1 >= int'(cap))
                begin
                    dec_fail   = 1'b1;
                    scan_phase = PH_DONE;
                end
                else if (c == CH_PERCENT)
                    esc_cnt = 2'd1;
                else
                begin
                    push_word(1'b0, (plus_space && c == CH_PLUS) ? CH_SPACE : c,
                              '0, '0, 1'b0);
                    dec_cnt++;
                end
            end
            else
            begin
                h = hex_nibble(c);
                if (h[4])
                begin
                    dec_fail   = 1'b1;
                    scan_phase = PH_DONE;
                    esc_cnt    = '0;
                end
                else if (esc_cnt == 2'd1)
                begin
                    esc_hi  = h[3:0];
                    esc_cnt = 2'd2;
                end
                else
                begin
                    push_word(1'b0, {esc_hi, h[3:0]}, '0, '0, 1'b0);
                    dec_cnt++;
                    esc_cnt = '0;
                end
            end
        endfunction

        // one accepted input word
        function void note_input(logic [7:0] c, logic empty, logic last);
            logic [2:0] code;
            if (empty)
            begin
                push_word(1'b1, 8'h00, (cap == 16'd0) ? ST_NOCAP : ST_EMPTY, '0, 1'b1);
                clear_run();
            end
            else
            begin
                if (scan_phase == PH_SEARCH)
                    scan_search(c);
                else if (scan_phase == PH_VALUE)
                    scan_value(c);
                if (last)
                begin
                    if (cap == 16'd0)
                        code = ST_NOCAP;
                    else if (scan_phase == PH_SEARCH)
                        code = ST_MISSING;
                    else if (dec_fail || esc_cnt != 0)
                        code = ST_FAILED;
                    else
                        code = ST_FOUND;
                    push_word(1'b1, 8'h00, code, (code == ST_FOUND) ? dec_cnt : 16'd0, 1'b1);
                    clear_run();
                end
            end
        endfunction

        function string show(result_t w);
            return $sformatf("st=%0b byte=%02h code=%0d len=%0d last=%0b", w.is_status,
                             w.value_byte, w.status_code, w.value_length, w.run_end);
        endfunction

        function void log_error(string what, result_t want, result_t got);
            errors++;
            if (errors <= 10)
                $display("ERROR %s: expected %s, got %s", what, show(want), show(got));
        endfunction

        // one accepted result word
        function void check_word(result_t got);
            result_t want;
            want = '0;
            if (expected_words.size() == 0)
                log_error("unexpected word", want, got);
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                    log_error("word mismatch", want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] char_in
    logic        s_tuser;     // [0] empty_string
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [7:0] value_byte, [10:8] status_code, [26:11] value_length
    logic        m_tuser;     // [0] is_status
    logic        m_tlast;

    idle_mode_t       idle_mode;
    logic             hold;
    logic             hold_go;
    int               items_sent;
    int               cycles;
    logic [7:0]       line_q[$];
    lookup_scoreboard sb = new();

    form_variable_extractor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int send_pct(idle_mode_t m);
        return (m == IDLE_SEND) ? 61 : (m == IDLE_BOTH) ? 10 : 0;
    endfunction

    function automatic int recv_pct(idle_mode_t m);
        return (m == IDLE_RECV) ? 61 : (m == IDLE_BOTH) ? 10 : 0;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] c, input logic empty, input logic last);
        int gap;
        gap = 0;
        while (roll(send_pct(idle_mode)))
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= empty;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(c, empty, last);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0, close && i == s.len() - 1);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_item(line_q[i], 1'b0, i == line_q.size() - 1);
    endtask

    // random bytes, sometimes with an empty-string word in place of one of them
    task automatic send_noise();
        int n;
        int cut;
        n   = $urandom_range(1, 8);
        cut = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : n;
        for (int i = 0; i < n; i++)
        begin
            if (i == cut)
                send_item(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
            else
                send_item(8'($urandom_range(255)), 1'b0, i == n - 1);
        end
    endtask

    // drain everything expected, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] len, input logic [63:0] capv,
                              input logic [63:0] plus);
        write_reg(REG_NAME_LOW, lo);
        write_reg(REG_NAME_HIGH, hi);
        write_reg(REG_NAME_LEN, len);
        write_reg(REG_CAPACITY, capv);
        write_reg(REG_PLUS, plus);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // String generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h61 : 8'h41);
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1))
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + v;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    function automatic logic [127:0] rand_name(bit any);
        logic [127:0] nm;
        for (int i = 0; i < NAME_BYTES; i++)
            nm[i*8 +: 8] = (any && $urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                           : rand_letter();
        return nm;
    endfunction

    // configured name, case scrambled; altered copies should miss
    function automatic void push_name(bit altered);
        int n;
        n = (sb.name_size > 5'(NAME_BYTES)) ? NAME_BYTES : int'(sb.name_size);
        for (int i = 0; i < n; i++)
            line_q.push_back(flip_case(sb.name_char(i)));
        if (altered)
        begin
            case ($urandom_range(2))
                0: if (n > 0) void'(line_q.pop_back());
                1: line_q.push_back(rand_letter());
                default: if (n > 0) line_q[line_q.size() - 1 - $urandom_range(n - 1)] ^= 8'h01;
            endcase
        end
    endfunction

    function automatic void push_value();
        int n;
        int pick;
        n = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(10);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                line_q.push_back(8'h21 + 8'($urandom_range(93)));
            else if (pick < 50)
                line_q.push_back(CH_PLUS);
            else if (pick < 75)
            begin
                line_q.push_back(CH_PERCENT);
                line_q.push_back(hex_char(4'($urandom_range(15))));
                line_q.push_back(hex_char(4'($urandom_range(15))));
            end
            else if (pick < 82)
            begin
                line_q.push_back(CH_PERCENT);
                line_q.push_back(8'($urandom_range(255)));
            end
            else
                line_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    function automatic void make_form();
        int segs;
        int pick;
        line_q.delete();
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++)
        begin
            if (s > 0)
                line_q.push_back(CH_AMP);
            pick = $urandom_range(9);
            if (pick < 5)
                push_name(1'b0);
            else if (pick < 7)
                push_name(1'b1);
            else
                repeat ($urandom_range(1, 5)) line_q.push_back(rand_letter());
            if ($urandom_range(9) != 0)
                line_q.push_back(CH_EQ);
            push_value();
        end
        if (line_q.size() == 0)
            line_q.push_back(CH_EQ);
    endfunction

    // register settings per random phase
    task automatic configure_phase(input int p);
        logic [127:0] nm;
        logic [63:0]  len;
        logic [63:0]  capv;
        logic [63:0]  plus;
        nm   = rand_name(1'b0);
        len  = 64'd5;
        capv = 64'd256;
        plus = 64'd1;
        case (p)
            1:
            begin
                nm   = rand_name(1'b1);
                len  = 64'd16;
                capv = 64'hFFFF;
                plus = 64'd0;
            end
            2:
            begin
                len  = 64'd31;    // above the name limit, clipped to 16
                capv = 64'($urandom_range(2, 12));
            end
            3:
            begin
                nm[15:8] = CH_AMP;    // such a name can never match
                len      = 64'd3;
                capv     = 64'd1;
                plus     = 64'($urandom_range(1));
            end
            4:
            begin
                nm   = rand_name(1'b1);
                len  = 64'd0;
                capv = 64'd0;
                plus = 64'd0;
            end
            5:
            begin
                // junk in the unused upper bits
                nm   = rand_name(1'b1);
                len  = {$urandom, $urandom};
                capv = {$urandom, $urandom};
                plus = {$urandom, $urandom};
                len[4:0]   = 5'($urandom_range(1, 16));
                capv[15:0] = 16'($urandom_range(2, 40));
            end
            6:
            begin
                nm  = rand_name(1'b1);
                len = 64'($urandom_range(4));
            end
            7:
            begin
                len  = 64'($urandom_range(1, 8));
                capv = 64'($urandom_range(3, 8));
                plus = 64'd0;
            end
            default: ;
        endcase
        set_config(nm[63:0], nm[127:64], len, capv, plus);
    endtask

    // ------------------------------------------------------------------------
    // Result side: check accepted words, then pick the next ready level
    // ------------------------------------------------------------------------
    initial
    begin
        result_t seen;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                seen.is_status    = m_tuser;
                seen.value_byte   = m_tdata[7:0];
                seen.status_code  = m_tdata[10:8];
                seen.value_length = m_tdata[26:11];
                seen.run_end      = m_tlast;
                sb.check_word(seen);
            end
            m_tready <= !(hold || roll(recv_pct(idle_mode)));
        end
    end

    // Long receiver hold-off, once, so the block backs up into its input
    initial
    begin
        hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int goal;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        hold_go    = 1'b0;
        idle_mode  = IDLE_NONE;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty name, so a leading '=' opens the value
        send_item(8'hFF, 1'b1, 1'b0);    // empty string with the final flag clear
        send_text("=%4a+", 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // name "aB", room for two bytes, '+' kept
        wait_idle();
        set_config(64'h4261, 64'h0, 64'd2, 64'd3, 64'd0);
        send_text("AB=+%7E", 1'b1);    // escape completes on the final word
        send_text("ab=%z", 1'b1);      // bad escape
        send_text("ab=xyz&q", 1'b1);   // overflow, then bytes after the value

        // zero capacity
        wait_idle();
        set_config(64'h4261, 64'h0, 64'd2, 64'd0, 64'd1);
        send_text("ab", 1'b1);
        send_item(8'h00, 1'b1, 1'b1);

        // random phases, idle mode cycling with the phase
        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            idle_mode <= idle_mode_t'(p % 4);
            configure_phase(p);
            if (p == 2)
                hold_go <= 1'b1;
            goal = items_sent + PHASE_WORDS;
            while (items_sent < goal)
            begin
                if ($urandom_range(4) == 0)
                    send_noise();
                else
                begin
                    make_form();
                    send_line();
                end
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== form_variable_extractor.f =====
sv/fve_pkg.sv
sv/form_variable_extractor.sv
sim/tb.sv
